// ----- hdl/hex_command_packet_parser_assert.svh -----
// Assertion macros shared by the parser checkers.
`ifndef HEX_COMMAND_PACKET_PARSER_ASSERT_SVH
`define HEX_COMMAND_PACKET_PARSER_ASSERT_SVH

// General property, checked on the rising clock edge, off while reset is asserted.
`define HCPP_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication: antecedent implies consequent in the same cycle.
`define HCPP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`HCPP_ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- hdl/hcpp_pkg.sv -----
// Shared constants and digit decode for the hex command packet parser.
package hcpp_pkg;

	// Parse phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SEQ    = 3'd1;
	localparam logic [2:0] PH_CMD    = 3'd2;
	localparam logic [2:0] PH_LEN_HI = 3'd3;
	localparam logic [2:0] PH_LEN_LO = 3'd4;
	localparam logic [2:0] PH_PAY_HI = 3'd5;
	localparam logic [2:0] PH_PAY_LO = 3'd6;

	// Result actions
	localparam logic [1:0] ACT_LED0   = 2'd0;
	localparam logic [1:0] ACT_LED1   = 2'd1;
	localparam logic [1:0] ACT_SERIAL = 2'd2;

	// Characters
	localparam logic [7:0] CH_OPEN   = 8'h5B; // '['
	localparam logic [7:0] CH_NINE   = 8'h39; // '9'
	localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
	localparam logic [7:0] CH_A      = 8'h41; // 'A'
	localparam logic [7:0] CH_UPMASK = 8'h5F;
	localparam logic [7:0] CMD_LED   = 8'h4C; // 'L'
	localparam logic [7:0] CMD_SER   = 8'h53; // 'S'

	// Hex digit decode, wraps mod 256 for non-hex characters.
	function automatic logic [7:0] hcpp_decode(input logic [7:0] ch);
		if (ch <= CH_NINE) begin
			return ch - CH_ZERO;
		end
		return (ch & CH_UPMASK) - CH_A + 8'd10;
	endfunction

endpackage

// ----- hdl/hcpp_rx_if.sv -----
// Character input channel: valid/ready handshake with one received byte.
interface hcpp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink (input valid, input rx_char, output ready);
endinterface

// ----- hdl/hcpp_act_if.sv -----
// Action output channel: valid/ready handshake with action code and value.
interface hcpp_act_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

// ----- hdl/hex_command_packet_parser.sv -----
// Hex command packet parser: one character per cycle in while not stalled, LED and serial actions out.
//
// Frame: '[' seq cmd len_hi len_lo then len payload hex digits (len of zero
// means 256 digits). Each payload digit pair forms a byte; command 'L' gives
// an LED action (bit 4 picks LED1, bit 0 is the level), command 'S' gives a
// serial byte, other commands drop their bytes. Characters outside a frame
// other than '[' are ignored. Throughput is one character per clock when not
// stalled. The accepting edge loads a character into the input register; the
// parse/result register is loaded when the input stage advances, and the action
// is presented from that register. The output register holds a result until
// taken while the input side keeps moving, so the block stalls only when a
// result is pending and not taken and the next character is already waiting
// in the input register. Parser state changes only when the input stage
// advances.
module hex_command_packet_parser (
	input logic         clk,
	input logic         arst_n,
	hcpp_rx_if.sink     rx,
	hcpp_act_if.source  act
);
	import hcpp_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       adv_s1;

	// Parser state
	logic [2:0] phase_q;
	logic [7:0] cmd_q;
	logic [7:0] left_q;
	logic [7:0] hi_q;

	logic [2:0] phase_nx;
	logic [7:0] cmd_nx;
	logic [7:0] left_nx;
	logic [7:0] hi_nx;

	// Result register
	logic       out_valid_q;
	logic [1:0] action_q;
	logic [7:0] value_q;

	logic       res_hit;
	logic [1:0] res_action;
	logic [7:0] res_value;

	logic [7:0] digit;
	logic [7:0] pair;
	logic [7:0] left_dec;

	// The input stage moves on whenever the result register is free or drains.
	assign adv_s1   = valid_s1 && (!out_valid_q || act.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			char_s1 <= rx.rx_char;
		end
	end

	assign digit    = hcpp_decode(char_s1);
	assign pair     = {hi_q[3:0], 4'h0} + digit;
	assign left_dec = left_q - 8'd1;

	// Next state and result for the character in the input stage
	always_comb begin
		phase_nx   = phase_q;
		cmd_nx     = cmd_q;
		left_nx    = left_q;
		hi_nx      = hi_q;
		res_hit    = 1'b0;
		res_action = ACT_SERIAL;
		res_value  = pair;
		case (phase_q)
			PH_SEQ: begin
				phase_nx = PH_CMD;
			end
			PH_CMD: begin
				cmd_nx   = char_s1;
				phase_nx = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				hi_nx    = digit;
				phase_nx = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				left_nx  = pair;
				phase_nx = PH_PAY_HI;
			end
			PH_PAY_HI: begin
				hi_nx    = digit;
				left_nx  = left_dec;
				phase_nx = (left_dec == 8'd0) ? PH_IDLE : PH_PAY_LO;
			end
			PH_PAY_LO: begin
				if (cmd_q == CMD_LED) begin
					res_hit    = 1'b1;
					res_action = pair[4] ? ACT_LED1 : ACT_LED0;
					res_value  = {7'd0, pair[0]};
				end else if (cmd_q == CMD_SER) begin
					res_hit    = 1'b1;
					res_action = ACT_SERIAL;
					res_value  = pair;
				end
				left_nx  = left_dec;
				phase_nx = (left_dec == 8'd0) ? PH_IDLE : PH_PAY_HI;
			end
			default: begin
				// idle, and any unused phase code
				phase_nx = (char_s1 == CH_OPEN) ? PH_SEQ : PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= 8'd0;
			left_q  <= 8'd0;
			hi_q    <= 8'd0;
		end else if (adv_s1) begin
			phase_q <= phase_nx;
			cmd_q   <= cmd_nx;
			left_q  <= left_nx;
			hi_q    <= hi_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res_hit;
		end else if (act.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_hit) begin
			action_q <= res_action;
			value_q  <= res_value;
		end
	end

	assign act.valid  = out_valid_q;
	assign act.action = action_q;
	assign act.value  = value_q;

endmodule

// ----- hdl/hcpp_checker.sv -----
// Port-level checker for the hex command packet parser, bound to the top level.
`include "hex_command_packet_parser_assert.svh"

module hcpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] action,
	input logic [7:0] value
);
	import hcpp_pkg::*;

	// A stalled transaction keeps its payload.
	`HCPP_ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(action) && $stable(value), "output transaction changed while stalled")

	`HCPP_ASSERT_IMPL(a_action_code, clk, arst_n, out_valid, action == ACT_LED0 || action == ACT_LED1 || action == ACT_SERIAL, "unknown action code")

	// LED actions carry a single level bit.
	`HCPP_ASSERT_IMPL(a_led_level, clk, arst_n, out_valid && (action == ACT_LED0 || action == ACT_LED1), value[7:1] == 7'd0, "LED action with level above one")

	// A fresh result is checked against an earlier accepted character.
	`HCPP_ASSERT_IMPL(a_result_latency, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without matching input transaction")

endmodule

bind hex_command_packet_parser hcpp_checker u_hcpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rx.valid),
	.in_ready  (rx.ready),
	.out_valid (act.valid),
	.out_ready (act.ready),
	.action    (act.action),
	.value     (act.value)
);
